>>> design/id_allocator_free_fifo_defines.svh
// Assertion helpers, clocked on clk, off while rst_n is low.
`ifndef ID_ALLOCATOR_FREE_FIFO_DEFINES_SVH
`define ID_ALLOCATOR_FREE_FIFO_DEFINES_SVH

// Same-cycle implication.
`define IDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/ida_pkg.sv
package ida_pkg;

    localparam int ID_BITS    = 8;
    localparam int POOL_DEPTH = 256;
    localparam int PTR_BITS   = $clog2(POOL_DEPTH);
    localparam int CNT_BITS   = $clog2(POOL_DEPTH + 1);

    localparam logic [ID_BITS-1:0] ID_MAX = '1;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } status_t;

    typedef struct packed {
        logic load_req;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] pool_count;
    } stat_t;

    function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] r;
        if (p == PTR_BITS'(POOL_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

endpackage

>>> design/ida_req_if.sv
interface ida_req_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [ida_pkg::ID_BITS-1:0] release_id;

    modport source (output valid, input ready, output func, output release_id);
    modport sink   (input valid, output ready, input func, input release_id);
endinterface

>>> design/ida_rsp_if.sv
interface ida_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ida_pkg::ID_BITS-1:0] granted_id;
    logic [1:0]                  status;

    modport source (output valid, input ready, output granted_id, output status);
    modport sink   (input valid, output ready, input granted_id, input status);
endinterface

>>> design/ida_ram.sv
module ida_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/ida_ctrl.sv
module ida_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output ida_pkg::cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign slot_free    = !out_valid_reg || out_ready;
    assign cmd.load_req = in_valid && (state_reg == S_IDLE);
    assign cmd.commit   = (state_reg == S_EXEC) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/ida_dpath.sv
module ida_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ida_pkg::cmd_t               cmd,
    input  logic                        func,
    input  logic [ida_pkg::ID_BITS-1:0] release_id,
    output logic [ida_pkg::ID_BITS-1:0] granted_id,
    output logic [1:0]                  status,
    output ida_pkg::stat_t              stat
);

    logic [ida_pkg::ID_BITS-1:0]  rid_reg;
    ida_pkg::func_t               func_reg;
    logic [ida_pkg::PTR_BITS-1:0] head_reg, head_next;
    logic [ida_pkg::PTR_BITS-1:0] tail_reg, tail_next;
    logic [ida_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic [ida_pkg::ID_BITS-1:0]  high_reg, high_next;
    logic [ida_pkg::ID_BITS-1:0]  gid_reg, gid_next;
    ida_pkg::status_t             status_reg, status_next;
    logic                         pool_we;
    logic [ida_pkg::ID_BITS-1:0]  pool_rdata;

    // Read port always points at the head; the item is latched in func_reg and
    // rid_reg before commit and the head moves only on commit, so the registered read is current at commit time.
    ida_ram #(
        .WIDTH (ida_pkg::ID_BITS),
        .DEPTH (ida_pkg::POOL_DEPTH)
    ) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (tail_reg),
        .wdata (rid_reg),
        .raddr (head_reg),
        .rdata (pool_rdata)
    );

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        high_next   = high_reg;
        gid_next    = '0;
        status_next = ida_pkg::ST_OK;
        pool_we     = 1'b0;
        if (func_reg == ida_pkg::FUNC_ALLOC)
        begin
            if (count_reg != '0)
            begin
                gid_next   = pool_rdata;
                head_next  = ida_pkg::ptr_next(head_reg);
                count_next = count_reg - 1'b1;
            end
            else if (high_reg == ida_pkg::ID_MAX)
            begin
                status_next = ida_pkg::ST_EXHAUSTED;
            end
            else
            begin
                high_next = high_reg + 1'b1;
                gid_next  = high_reg + 1'b1;
            end
        end
        else
        begin
            if (rid_reg == '0 || rid_reg > high_reg)
            begin
                status_next = ida_pkg::ST_INVALID;
            end
            else if (rid_reg == high_reg)
            begin
                high_next = high_reg - 1'b1;
                gid_next  = rid_reg;
            end
            else if (count_reg == ida_pkg::CNT_BITS'(ida_pkg::POOL_DEPTH))
            begin
                status_next = ida_pkg::ST_INVALID;
            end
            else
            begin
                pool_we    = cmd.commit;
                tail_next  = ida_pkg::ptr_next(tail_reg);
                count_next = count_reg + 1'b1;
                gid_next   = rid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            high_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            high_reg  <= high_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            func_reg <= ida_pkg::func_t'(func);
            rid_reg  <= release_id;
        end
        if (cmd.commit)
        begin
            gid_reg    <= gid_next;
            status_reg <= status_next;
        end
    end

    assign granted_id      = gid_reg;
    assign status          = status_reg;
    assign stat.pool_count = count_reg;

endmodule

>>> design/id_allocator_free_fifo.sv
// Unique-id allocator. An allocate (func 0) returns the oldest released id
// from a FIFO pool, or a fresh id above the high-water mark when the pool is
// empty (status 1, id 0 once every id is in use). A release (func 1) of the
// mark lowers it, any other id up to the mark goes to the pool; a release of
// 0, above the mark, or into a full pool returns status 2 and changes
// nothing. Double releases are not detected. Each item is latched on
// leaving S_IDLE while the pool RAM reads its head entry, and committed
// in S_EXEC. A finished result waits in the output register
// while the next item is taken; commit stalls only while that register is
// still full. The pool RAM needs no clearing after reset.
`include "id_allocator_free_fifo_defines.svh"

module id_allocator_free_fifo (
    input  logic      clk,
    input  logic      rst_n,
    ida_req_if.sink   req,
    ida_rsp_if.source rsp
);

    ida_pkg::cmd_t  cmd;
    ida_pkg::stat_t stat;

    ida_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    ida_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (req.func),
        .release_id (req.release_id),
        .granted_id (rsp.granted_id),
        .status     (rsp.status),
        .stat       (stat)
    );

    `IDA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
    `IDA_ASSERT_NOW(a_err_zero_id, rsp.valid && rsp.status != ida_pkg::ST_OK, rsp.granted_id == '0, "error with nonzero id")
    `IDA_ASSERT_NOW(a_ok_nonzero_id, rsp.valid && rsp.status == ida_pkg::ST_OK, rsp.granted_id != '0, "ok with id zero")
    `IDA_ASSERT_NOW(a_pool_bound, 1'b1, stat.pool_count <= ida_pkg::CNT_BITS'(ida_pkg::POOL_DEPTH), "pool overfill")

endmodule
